### rtl/tcfs_pkg.sv
`default_nettype none

package tcfs_pkg;

    localparam int DUTY_BITS_DEF     = 13;
    localparam int COUNT_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int CMD_W     = 2;
    localparam int LEVEL_W   = 8;
    localparam int LEN_W     = 16;
    localparam int LEVEL_MAX = 255;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_GLOW  = 2'd1,
        CMD_BLINK = 2'd2,
        CMD_STOP  = 2'd3
    } t_cmd;

endpackage

`default_nettype wire

### rtl/tcfs_if.sv
`default_nettype none

interface tcfs_in_if;
    import tcfs_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
    logic [LEN_W-1:0]   ramp_steps;
    logic [LEN_W-1:0]   hold_ticks;
    logic               no_preempt;

    modport source (
        output valid, command, green_level, blue_level, ramp_steps, hold_ticks, no_preempt,
        input  ready
    );
    modport sink (
        input  valid, command, green_level, blue_level, ramp_steps, hold_ticks, no_preempt,
        output ready
    );
endinterface

interface tcfs_out_if #(
    parameter int DUTY_BITS = tcfs_pkg::DUTY_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [DUTY_BITS-1:0] green_duty;
    logic [DUTY_BITS-1:0] blue_duty;
    logic                 running;

    modport source (
        output valid, green_duty, blue_duty, running,
        input  ready
    );
    modport sink (
        input  valid, green_duty, blue_duty, running,
        output ready
    );
endinterface

`default_nettype wire

### rtl/tcfs_serdiv.sv
`default_nettype none

module tcfs_serdiv #(
    parameter int DW = 25,
    parameter int VW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output logic               o_done,
    output logic [DW-1:0]      o_quotient
);
    localparam int CW = (DW > 1) ? $clog2(DW) : 1;

    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [VW:0]   sh;
    logic [VW:0]   diff;
    logic          ge;
    logic [VW-1:0] n_rem;

    // one quotient bit a cycle, MSB first; quotient bits shift in behind the dividend
    always_comb begin
        sh    = {r_rem, r_quo[DW-1]};
        diff  = sh - {1'b0, r_dvs};
        ge    = (sh >= {1'b0, r_dvs});
        n_rem = ge ? diff[VW-1:0] : sh[VW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_quo <= {r_quo[DW-2:0], ge};
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy) && !r_busy)
        else $error("divider done without a running division");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_cnt != '0 && r_dvs != '0 |-> r_rem < r_dvs)
        else $error("partial remainder not below divisor");
`endif

endmodule

`default_nettype wire

### rtl/two_channel_led_fade_sequencer.sv
`default_nettype none
// Ramp ticks run the bit-serial accumulator over ACC_W bits, then ST_LVL, ST_MUL, ST_DUTY
// (divide; DW = divider width, 25 at default widths) and ST_DONE; other ticks, stops, ignored
// starts and ramp-less starts skip the accumulator; other starts divide first in ST_DIV. A
// result not yet collected holds ST_DONE. One word is in flight at a time; the next is taken
// once the result is registered. Cost is set by the bit-serial accumulator and the two
// one-bit-a-cycle dividers. Reset (synchronous, active low) leaves it idle with no word pending.

module two_channel_led_fade_sequencer #(
    parameter int DUTY_BITS     = tcfs_pkg::DUTY_BITS_DEF,
    parameter int COUNT_BITS    = tcfs_pkg::COUNT_BITS_DEF,
    parameter int FRACTION_BITS = tcfs_pkg::FRACTION_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tcfs_in_if.sink     i_cmd,
    tcfs_out_if.source  o_res
);
    import tcfs_pkg::*;

    localparam int ACC_W = LEVEL_W + FRACTION_BITS;
    localparam int NUM_W = ((ACC_W > COUNT_BITS) ? ACC_W : COUNT_BITS) + 1;
    localparam int XW    = DUTY_BITS + LEVEL_W;
    localparam int DW    = (NUM_W > XW) ? NUM_W : XW;
    localparam int ABW   = $clog2(ACC_W);

    localparam logic [31:0]          CNT_MAX32  = 32'((64'd1 << COUNT_BITS) - 64'd1);
    localparam logic [DUTY_BITS-1:0] DUTY_MAX_C = '1;
    localparam logic [ACC_W:0]       HALF       = (ACC_W+1)'(1) << (FRACTION_BITS - 1);
    localparam logic [COUNT_BITS-1:0] DIV_LEVEL = COUNT_BITS'(LEVEL_MAX);

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_ACC, ST_LVL, ST_MUL, ST_DUTY, ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_IDLE, PH_UP, PH_HOLD, PH_DOWN
    } t_phase;

    t_state               r_st, n_st;
    t_phase               r_phase, n_phase;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic [COUNT_BITS-1:0] r_t, n_t;
    logic [COUNT_BITS-1:0] r_h, n_h;
    logic                 r_rep, n_rep;
    logic                 r_stop, n_stop;
    logic [ACC_W-1:0]     r_acc_g, n_acc_g, r_acc_b, n_acc_b;
    logic [ACC_W-1:0]     r_inc_g, n_inc_g, r_inc_b, n_inc_b;
    logic                 r_sub, n_sub;
    logic                 r_cy_g, n_cy_g, r_cy_b, n_cy_b;
    logic [ABW-1:0]       r_bit, n_bit;
    logic [LEVEL_W-1:0]   r_lvl_g, n_lvl_g, r_lvl_b, n_lvl_b;
    logic                 r_ov, n_ov;
    logic [DUTY_BITS-1:0] r_gd, n_gd, r_bd, n_bd;
    logic                 r_run, n_run;

    logic                 accept;
    t_cmd                 cmd;
    logic [31:0]          t32, h32;
    logic [COUNT_BITS-1:0] sat_t, sat_h;
    logic [COUNT_BITS:0]  cnt1;
    logic                 do_end, do_start, start_blink, acc_go, acc_sub;
    logic                 a_g, b_g, s_g, co_g, a_b, b_b, s_b, co_b;
    logic [ACC_W:0]       rnd_g, rnd_b;
    logic [LEVEL_W:0]     lvl9_g, lvl9_b;
    logic [XW-1:0]        x_g, x_b;
    logic [DW-1:0]        inc_dvd_g, inc_dvd_b;

    logic                 div_start;
    logic [DW-1:0]        div_dvd_g, div_dvd_b;
    logic [COUNT_BITS-1:0] div_dvs;
    logic                 done_g, done_b, div_done;
    logic [DW-1:0]        q_g, q_b;

    assign accept      = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_st == ST_IDLE);
    assign cmd         = t_cmd'(i_cmd.command);

    // clamp lengths to the counter range
    always_comb begin
        t32   = 32'(i_cmd.ramp_steps);
        h32   = 32'(i_cmd.hold_ticks);
        sat_t = (t32 > CNT_MAX32) ? '1 : t32[COUNT_BITS-1:0];
        sat_h = (h32 > CNT_MAX32) ? '1 : h32[COUNT_BITS-1:0];
    end

    // bit-serial add or subtract, LSB first; sum and difference bits coincide
    always_comb begin
        a_g  = r_acc_g[0];
        b_g  = r_inc_g[0];
        s_g  = a_g ^ b_g ^ r_cy_g;
        co_g = r_sub ? ((~a_g & b_g) | (~a_g & r_cy_g) | (b_g & r_cy_g))
                     : ((a_g & b_g) | (r_cy_g & (a_g ^ b_g)));
        a_b  = r_acc_b[0];
        b_b  = r_inc_b[0];
        s_b  = a_b ^ b_b ^ r_cy_b;
        co_b = r_sub ? ((~a_b & b_b) | (~a_b & r_cy_b) | (b_b & r_cy_b))
                     : ((a_b & b_b) | (r_cy_b & (a_b ^ b_b)));
    end

    always_comb begin
        rnd_g     = {1'b0, r_acc_g} + HALF;
        rnd_b     = {1'b0, r_acc_b} + HALF;
        lvl9_g    = rnd_g[ACC_W:FRACTION_BITS];
        lvl9_b    = rnd_b[ACC_W:FRACTION_BITS];
        x_g       = XW'(DUTY_MAX_C) * XW'(r_lvl_g);
        x_b       = XW'(DUTY_MAX_C) * XW'(r_lvl_b);
        inc_dvd_g = (DW'(i_cmd.green_level) << FRACTION_BITS) + DW'(sat_t >> 1);
        inc_dvd_b = (DW'(i_cmd.blue_level) << FRACTION_BITS) + DW'(sat_t >> 1);
    end

    assign div_dvd_g = (r_st == ST_MUL) ? DW'(x_g) : inc_dvd_g;
    assign div_dvd_b = (r_st == ST_MUL) ? DW'(x_b) : inc_dvd_b;
    assign div_dvs   = (r_st == ST_MUL) ? DIV_LEVEL : sat_t;
    assign div_done  = done_g & done_b;

    always_comb begin
        n_st    = r_st;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_t     = r_t;
        n_h     = r_h;
        n_rep   = r_rep;
        n_stop  = r_stop;
        n_acc_g = r_acc_g;
        n_acc_b = r_acc_b;
        n_inc_g = r_inc_g;
        n_inc_b = r_inc_b;
        n_sub   = r_sub;
        n_cy_g  = r_cy_g;
        n_cy_b  = r_cy_b;
        n_bit   = r_bit;
        n_lvl_g = r_lvl_g;
        n_lvl_b = r_lvl_b;
        n_ov    = r_ov;
        n_gd    = r_gd;
        n_bd    = r_bd;
        n_run   = r_run;

        do_end      = 1'b0;
        do_start    = 1'b0;
        start_blink = 1'b0;
        acc_go      = 1'b0;
        acc_sub     = 1'b0;
        div_start   = 1'b0;
        cnt1        = {1'b0, r_cnt} + 1'b1;

        if (r_ov && o_res.ready) begin
            n_ov = 1'b0;
        end

        case (r_st)
            ST_IDLE: begin
                if (accept) begin
                    case (cmd)
                        CMD_TICK: begin
                            case (r_phase)
                                PH_UP: begin
                                    if (r_t == '0) begin
                                        do_end = 1'b1;
                                    end else begin
                                        acc_go = 1'b1;
                                        if (cnt1 >= {1'b0, r_t}) begin
                                            n_cnt   = '0;
                                            // skip an empty hold
                                            n_phase = (r_h == '0) ? PH_DOWN : PH_HOLD;
                                        end else begin
                                            n_cnt = cnt1[COUNT_BITS-1:0];
                                        end
                                    end
                                end
                                PH_HOLD: begin
                                    if (cnt1 >= {1'b0, r_h}) begin
                                        n_cnt = '0;
                                        if (r_t == '0) begin
                                            do_end = 1'b1;
                                        end else begin
                                            n_phase = PH_DOWN;
                                        end
                                    end else begin
                                        n_cnt = cnt1[COUNT_BITS-1:0];
                                    end
                                end
                                PH_DOWN: begin
                                    if (cnt1 >= {1'b0, r_t}) begin
                                        do_end = 1'b1;
                                    end else begin
                                        acc_go  = 1'b1;
                                        acc_sub = 1'b1;
                                        n_cnt   = cnt1[COUNT_BITS-1:0];
                                    end
                                end
                                default: ;
                            endcase
                        end
                        CMD_GLOW: begin
                            if (!(i_cmd.no_preempt && r_phase != PH_IDLE)) begin
                                do_start = 1'b1;
                            end
                        end
                        CMD_BLINK: begin
                            do_start    = 1'b1;
                            start_blink = 1'b1;
                        end
                        CMD_STOP: begin
                            if (r_phase != PH_IDLE) begin
                                n_stop = 1'b1;
                            end
                        end
                        default: ;
                    endcase

                    n_st = ST_LVL;

                    if (do_end) begin
                        n_acc_g = '0;
                        n_acc_b = '0;
                        n_cnt   = '0;
                        if (r_rep && !r_stop) begin
                            n_phase = PH_UP;
                        end else begin
                            n_phase = PH_IDLE;
                            n_stop  = 1'b0;
                        end
                    end

                    if (acc_go) begin
                        n_st   = ST_ACC;
                        n_sub  = acc_sub;
                        n_cy_g = 1'b0;
                        n_cy_b = 1'b0;
                        n_bit  = '0;
                    end

                    if (do_start) begin
                        n_t     = sat_t;
                        n_h     = start_blink ? '0 : sat_h;
                        n_rep   = start_blink;
                        n_stop  = 1'b0;
                        n_acc_g = '0;
                        n_acc_b = '0;
                        n_cnt   = '0;
                        if (sat_t == '0) begin
                            n_inc_g = '0;
                            n_inc_b = '0;
                            if (start_blink) begin
                                n_phase = PH_UP;
                            end else begin
                                // dark glow: hold only, or over at once
                                n_phase = (sat_h == '0) ? PH_IDLE : PH_HOLD;
                            end
                        end else begin
                            n_phase   = PH_UP;
                            div_start = 1'b1;
                            n_st      = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_inc_g = q_g[ACC_W-1:0];
                    n_inc_b = q_b[ACC_W-1:0];
                    n_st    = ST_LVL;
                end
            end
            ST_ACC: begin
                n_acc_g = {s_g, r_acc_g[ACC_W-1:1]};
                n_acc_b = {s_b, r_acc_b[ACC_W-1:1]};
                n_inc_g = {r_inc_g[0], r_inc_g[ACC_W-1:1]};
                n_inc_b = {r_inc_b[0], r_inc_b[ACC_W-1:1]};
                n_cy_g  = co_g;
                n_cy_b  = co_b;
                n_bit   = r_bit + 1'b1;
                if (r_bit == ABW'(ACC_W - 1)) begin
                    // clamp a down step that would go below zero
                    if (r_sub && co_g) begin
                        n_acc_g = '0;
                    end
                    if (r_sub && co_b) begin
                        n_acc_b = '0;
                    end
                    n_st = ST_LVL;
                end
            end
            ST_LVL: begin
                n_lvl_g = lvl9_g[LEVEL_W] ? '1 : lvl9_g[LEVEL_W-1:0];
                n_lvl_b = lvl9_b[LEVEL_W] ? '1 : lvl9_b[LEVEL_W-1:0];
                n_st    = ST_MUL;
            end
            ST_MUL: begin
                div_start = 1'b1;
                n_st      = ST_DUTY;
            end
            ST_DUTY: begin
                if (div_done) begin
                    n_st = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_ov || o_res.ready) begin
                    n_ov  = 1'b1;
                    n_gd  = q_g[DUTY_BITS-1:0];
                    n_bd  = q_b[DUTY_BITS-1:0];
                    n_run = (r_phase != PH_IDLE);
                    n_st  = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_IDLE;
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_rep   <= 1'b0;
            r_stop  <= 1'b0;
            r_acc_g <= '0;
            r_acc_b <= '0;
            r_bit   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_t     <= n_t;
            r_h     <= n_h;
            r_rep   <= n_rep;
            r_stop  <= n_stop;
            r_acc_g <= n_acc_g;
            r_acc_b <= n_acc_b;
            r_inc_g <= n_inc_g;
            r_inc_b <= n_inc_b;
            r_sub   <= n_sub;
            r_cy_g  <= n_cy_g;
            r_cy_b  <= n_cy_b;
            r_bit   <= n_bit;
            r_lvl_g <= n_lvl_g;
            r_lvl_b <= n_lvl_b;
            r_ov    <= n_ov;
            r_gd    <= n_gd;
            r_bd    <= n_bd;
            r_run   <= n_run;
        end
    end

    tcfs_serdiv #(
        .DW (DW),
        .VW (COUNT_BITS)
    ) u_div_g (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd_g),
        .i_divisor  (div_dvs),
        .o_done     (done_g),
        .o_quotient (q_g)
    );

    tcfs_serdiv #(
        .DW (DW),
        .VW (COUNT_BITS)
    ) u_div_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd_b),
        .i_divisor  (div_dvs),
        .o_done     (done_b),
        .o_quotient (q_b)
    );

    assign o_res.valid      = r_ov;
    assign o_res.green_duty = r_gd;
    assign o_res.blue_duty  = r_bd;
    assign o_res.running    = r_run;

`ifndef SYNTHESIS
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_cnt == '0 && !r_stop)
        else $error("idle sequencer with count or pending stop");
    a_acc_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == ST_ACC |-> r_phase != PH_IDLE)
        else $error("accumulator stepping while idle");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_UP || r_phase == PH_DOWN) && r_t != '0 |-> r_cnt < r_t)
        else $error("ramp count beyond ramp length");
    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_st == ST_DONE))
        else $error("result word raised outside the done state");
`endif

endmodule

`default_nettype wire
